@@ sv/safp_pkg.sv @@
// ----------------------------------------------------------------------------
// safp_pkg
// Shared types and character codes for the sentence angle field parser.
// ----------------------------------------------------------------------------
package safp_pkg;

   localparam logic [1:0] PHASE_BLANKS  = 2'd0;
   localparam logic [1:0] PHASE_DIGITS  = 2'd1;
   localparam logic [1:0] PHASE_STOPPED = 2'd2;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [2:0] FIELD_ID    = 3'd1;
   localparam logic [2:0] FIELD_ROLL  = 3'd2;
   localparam logic [2:0] FIELD_PITCH = 3'd3;
   localparam logic [2:0] FIELD_YAW   = 3'd4;
   localparam logic [2:0] FIELD_MAX   = 3'd7;

   typedef struct packed {
      logic [1:0] phase;
      logic       neg;
      logic       dot;
   } field_state_type;

endpackage

@@ sv/safp_field_conv.sv @@
// ----------------------------------------------------------------------------
// safp_field_conv
// One conversion step of a field: blank skip, sign, first dot drop and a
// saturating multiply-by-ten accumulate of the decimal magnitude.
// ----------------------------------------------------------------------------
module safp_field_conv
   import safp_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic [7:0]             text_byte,
   input  field_state_type        cur_state,
   input  logic [VALUE_WIDTH-1:0] cur_acc,
   output field_state_type        nxt_state,
   output logic [VALUE_WIDTH-1:0] nxt_acc
);

   localparam int PROD_WIDTH = VALUE_WIDTH + 4;

   logic                   is_digit;
   logic                   is_blank;
   logic                   is_sign;
   logic [3:0]             digit;
   logic [VALUE_WIDTH-1:0] limit;
   logic [PROD_WIDTH-1:0]  acc_ext;
   logic [PROD_WIDTH-1:0]  prod;

   always_comb begin
      is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
      is_blank = text_byte inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
      is_sign  = (text_byte == CHAR_PLUS) || (text_byte == CHAR_MINUS);
      digit    = 4'(text_byte - CHAR_ZERO);
      limit    = {1'b1, {(VALUE_WIDTH-1){1'b0}}} - VALUE_WIDTH'(!cur_state.neg);
      acc_ext  = PROD_WIDTH'(cur_acc);
      prod     = (acc_ext << 3) + (acc_ext << 1) + PROD_WIDTH'(digit);

      nxt_state = cur_state;
      nxt_acc   = cur_acc;
      if ((text_byte == CHAR_DOT) && !cur_state.dot) begin
         nxt_state.dot = 1'b1;
      end else if ((cur_state.phase == PHASE_BLANKS) && is_blank) begin
         nxt_state = cur_state;
      end else if ((cur_state.phase == PHASE_BLANKS) && is_sign) begin
         nxt_state.neg   = (text_byte == CHAR_MINUS);
         nxt_state.phase = PHASE_DIGITS;
      end else if ((cur_state.phase <= PHASE_DIGITS) && is_digit) begin
         if (prod > PROD_WIDTH'(limit)) begin
            nxt_acc = limit;
         end else begin
            nxt_acc = prod[VALUE_WIDTH-1:0];
         end
         nxt_state.phase = PHASE_DIGITS;
      end else begin
         nxt_state.phase = PHASE_STOPPED;
      end
   end

endmodule

@@ sv/sentence_angle_field_parser.sv @@
// ----------------------------------------------------------------------------
// sentence_angle_field_parser
// Parses comma separated sentences into sensor id, roll, pitch and yaw.
// ----------------------------------------------------------------------------
// Takes one sentence byte per cycle, with no gaps needed between bytes or
// sentences; a last byte waits on a full output. A byte passes an input
// register, then one conversion step (a saturating multiply-by-ten
// accumulate) updates the parse state; a sentence's result is registered
// with its last byte. The multiply-by-ten add and limit compare at
// VALUE_WIDTH+4 bits is the longest path. Angles come out in hundredths of
// a degree with the first dot of each field dropped; absent fields read zero.
// ----------------------------------------------------------------------------
module sentence_angle_field_parser
   import safp_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_text_byte,
   input  logic               req_first_of_sentence,
   input  logic               req_last_of_sentence,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sensor_id,
   output logic signed [31:0] rsp_roll_hundredths,
   output logic signed [31:0] rsp_pitch_hundredths,
   output logic signed [31:0] rsp_yaw_hundredths,
   output logic [2:0]         rsp_fields_found
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_first_ff;
   logic                   in_last_ff;

   logic [2:0]             field_num_ff, field_num_in;
   field_state_type        fstate_ff, fstate_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic signed [31:0]     id_ff, id_in;
   logic signed [31:0]     roll_ff, roll_in;
   logic signed [31:0]     pitch_ff, pitch_in;
   logic signed [31:0]     yaw_ff, yaw_in;

   logic                   out_valid_ff, out_valid_in;
   logic signed [31:0]     out_id_ff, out_roll_ff, out_pitch_ff, out_yaw_ff;
   logic [2:0]             out_found_ff;

   logic                   accept;
   logic                   out_free;
   logic                   advance;
   logic                   emit;
   logic                   delim;
   logic                   commit;

   logic [2:0]             field_num_eff;
   field_state_type        fstate_eff;
   logic [VALUE_WIDTH-1:0] acc_eff;
   field_state_type        fstate_fed;
   logic [VALUE_WIDTH-1:0] acc_fed;
   field_state_type        src_state;
   logic [VALUE_WIDTH-1:0] src_acc;
   logic signed [VALUE_WIDTH-1:0] src_value;
   logic signed [31:0]     commit_value;
   logic signed [31:0]     id_new, roll_new, pitch_new, yaw_new;
   logic [2:0]             found;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign emit      = advance && in_last_ff;
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   safp_field_conv #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_conv (
      .text_byte (in_byte_ff),
      .cur_state (fstate_eff),
      .cur_acc   (acc_eff),
      .nxt_state (fstate_fed),
      .nxt_acc   (acc_fed)
   );

   always_comb begin
      if (in_first_ff) begin
         field_num_eff = '0;
         fstate_eff    = '{phase: PHASE_BLANKS, neg: 1'b0, dot: 1'b0};
         acc_eff       = '0;
         id_new        = '0;
         roll_new      = '0;
         pitch_new     = '0;
         yaw_new       = '0;
      end else begin
         field_num_eff = field_num_ff;
         fstate_eff    = fstate_ff;
         acc_eff       = acc_ff;
         id_new        = id_ff;
         roll_new      = roll_ff;
         pitch_new     = pitch_ff;
         yaw_new       = yaw_ff;
      end

      delim     = (in_byte_ff == CHAR_COMMA) || (in_byte_ff == CHAR_STAR);
      commit    = delim || in_last_ff;
      src_state = delim ? fstate_eff : fstate_fed;
      src_acc   = delim ? acc_eff : acc_fed;
      src_value = src_state.neg ? signed'(VALUE_WIDTH'(-src_acc)) : signed'(src_acc);
      commit_value = 32'(src_value);

      if (commit) begin
         case (field_num_eff)
            FIELD_ID:    id_new    = commit_value;
            FIELD_ROLL:  roll_new  = commit_value;
            FIELD_PITCH: pitch_new = commit_value;
            FIELD_YAW:   yaw_new   = commit_value;
            default:     id_new    = id_new;
         endcase
      end

      if (field_num_eff != FIELD_MAX) begin
         found = field_num_eff + 3'd1;
      end else begin
         found = field_num_eff;
      end

      if (in_last_ff) begin
         field_num_in = '0;
         fstate_in    = '{phase: PHASE_BLANKS, neg: 1'b0, dot: 1'b0};
         acc_in       = '0;
         id_in        = '0;
         roll_in      = '0;
         pitch_in     = '0;
         yaw_in       = '0;
      end else begin
         if (delim && (field_num_eff != FIELD_MAX)) begin
            field_num_in = field_num_eff + 3'd1;
         end else begin
            field_num_in = field_num_eff;
         end
         if (delim) begin
            fstate_in = '{phase: PHASE_BLANKS, neg: 1'b0, dot: 1'b0};
         end else begin
            fstate_in = fstate_fed;
         end
         acc_in    = delim ? '0 : acc_fed;
         id_in     = id_new;
         roll_in   = roll_new;
         pitch_in  = pitch_new;
         yaw_in    = yaw_new;
      end
   end

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         field_num_ff <= '0;
         fstate_ff    <= '{phase: PHASE_BLANKS, neg: 1'b0, dot: 1'b0};
         acc_ff       <= '0;
         id_ff        <= '0;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            field_num_ff <= field_num_in;
            fstate_ff    <= fstate_in;
            acc_ff       <= acc_in;
            id_ff        <= id_in;
            roll_ff      <= roll_in;
            pitch_ff     <= pitch_in;
            yaw_ff       <= yaw_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_text_byte;
         in_first_ff <= req_first_of_sentence;
         in_last_ff  <= req_last_of_sentence;
      end
      if (emit) begin
         out_id_ff    <= id_new;
         out_roll_ff  <= roll_new;
         out_pitch_ff <= pitch_new;
         out_yaw_ff   <= yaw_new;
         out_found_ff <= found;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_sensor_id        = out_id_ff;
   assign rsp_roll_hundredths  = out_roll_ff;
   assign rsp_pitch_hundredths = out_pitch_ff;
   assign rsp_yaw_hundredths   = out_yaw_ff;
   assign rsp_fields_found     = out_found_ff;

endmodule
